[design/vibrance_rgb565_pixel_packer_defines.svh]
// ---------------------------------------------------------------------------
// vibrance rgb565 pixel packer: assertion macros
// concurrent checks clocked on clk; empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef VIBRANCE_RGB565_PIXEL_PACKER_DEFINES_SVH
`define VIBRANCE_RGB565_PIXEL_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// check that is held off while reset is applied
`define VRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vrp check failed");

// check that also runs through reset
`define VRP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vrp reset check failed");

`else

`define VRP_ASSERT(lbl, prop)
`define VRP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[design/vrp_pkg.sv]
// ---------------------------------------------------------------------------
// vrp_pkg
// shared types, constants and the rgb565 packing function for the
// vibrance pixel packer
// ---------------------------------------------------------------------------
package vrp_pkg;

  // chroma gate and weighting
  localparam int unsigned CHROMA_FLOOR = 24;
  localparam int unsigned CHROMA_SPAN  = 40;
  localparam int unsigned CHROMA_TOP   = CHROMA_FLOOR + CHROMA_SPAN;
  localparam int unsigned NEUTRAL_PCT  = 100;

  // integer luma weights, sum is 256
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  // saturation register reset value
  localparam logic [8:0] SAT_RESET = 9'd100;

  // reciprocal for divide by 40, exact for magnitudes below 2^15
  localparam logic [14:0] DIV40_MUL   = 15'd26215;
  localparam int unsigned DIV40_SHIFT = 20;

  // reciprocal for divide by 100, exact for magnitudes below 2^17
  localparam logic [17:0] DIV100_MUL   = 18'd167773;
  localparam int unsigned DIV100_SHIFT = 24;

  typedef logic [7:0]        chan_t;
  typedef logic signed [8:0] diff_t;
  typedef logic [8:0]        pct_t;

  // pixel carried down the pipeline next to the valid bits
  typedef struct packed {
    logic        bypass;
    chan_t [2:0] rgb;     // [2] red, [1] green, [0] blue
  } pix_t;

  // rgb565 word with its two bytes swapped
  function automatic logic [15:0] pack_swapped(chan_t r, chan_t g, chan_t b);
    logic [15:0] w;
    w = {r[7:3], g[7:2], b[7:3]};
    return {w[7:0], w[15:8]};
  endfunction

endpackage

[design/vibrance_rgb565_pixel_packer.sv]
// ---------------------------------------------------------------------------
// vibrance_rgb565_pixel_packer
// chroma-weighted vibrance on one rgb888 pixel, packed to a byte-swapped
// rgb565 panel word
// ---------------------------------------------------------------------------
// out_valid is registered at the end of the valid_r shift chain, in step with the payload
// throughput: one pixel per clock, busy stays low, the result side never stalls
// depth is set by the two reciprocal divides, each behind its own multiplier
// reset (synchronous, rst_n low) empties the pipeline and sets saturation to 100
`include "vibrance_rgb565_pixel_packer_defines.svh"

module vibrance_rgb565_pixel_packer
  import vrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  output logic [15:0] out_panel_word
);

  pct_t               sat_r;
  logic [8:1]         valid_r;
  pix_t               pix_r [1:8];

  chan_t              hi;
  chan_t              lo;
  chan_t              chroma;
  chan_t              wsub;
  logic               bypass_nxt;
  logic [5:0]         weight2_r;
  logic [15:0]        luma_sum;
  chan_t              luma2_r;

  logic signed [9:0]  sat_off;
  logic signed [16:0] wprod;
  logic signed [16:0] wprod_r;
  diff_t              diff3_r [3];
  chan_t              luma3_r;

  logic [14:0]        wmag;
  logic [29:0]        wquo;
  logic [8:0]         q4_r;
  logic               neg4_r;
  diff_t              diff4_r [3];
  chan_t              luma4_r;

  pct_t               eff5_r;
  diff_t              diff5_r [3];
  chan_t              luma5_r;

  chan_t              chan8 [3];
  logic               out_valid_r;
  logic [15:0]        out_word_r;
  logic [15:0]        out_word_nxt;

  // pipeline never holds off a beat
  assign busy = 1'b0;

  // saturation register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= SAT_RESET;
    end else if (cfg_we) begin
      sat_r <= cfg_wdata;
    end
  end

  // chroma, weight and bypass decision on stage 1
  always_comb begin
    hi = pix_r[1].rgb[2];
    lo = pix_r[1].rgb[2];
    if (pix_r[1].rgb[1] > hi) hi = pix_r[1].rgb[1];
    if (pix_r[1].rgb[0] > hi) hi = pix_r[1].rgb[0];
    if (pix_r[1].rgb[1] < lo) lo = pix_r[1].rgb[1];
    if (pix_r[1].rgb[0] < lo) lo = pix_r[1].rgb[0];
    chroma     = hi - lo;
    wsub       = chroma - 8'(CHROMA_FLOOR);
    bypass_nxt = (chroma <= 8'(CHROMA_FLOOR)) || (sat_r == 9'(NEUTRAL_PCT));
  end

  // integer luma
  assign luma_sum = {8'd0, pix_r[1].rgb[2]} * LUMA_R
                  + {8'd0, pix_r[1].rgb[1]} * LUMA_G
                  + {8'd0, pix_r[1].rgb[0]} * LUMA_B;

  // percent offset times weight
  assign sat_off = $signed({1'b0, sat_r}) - 10'sd100;
  assign wprod   = sat_off * $signed({1'b0, weight2_r});

  // divide by 40 toward zero
  assign wmag = wprod_r[16] ? 15'(-wprod_r) : wprod_r[14:0];
  assign wquo = {15'd0, wmag} * {15'd0, DIV40_MUL};

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= {valid_r[7:1], start & ~busy};
      out_valid_r <= valid_r[8];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    pix_r[1].bypass <= 1'b0;
    pix_r[1].rgb    <= {in_red_in, in_green_in, in_blue_in};
    pix_r[2].bypass <= bypass_nxt;
    pix_r[2].rgb    <= pix_r[1].rgb;
    for (int i = 3; i <= 8; i++) begin
      pix_r[i] <= pix_r[i-1];
    end

    weight2_r <= (chroma > 8'(CHROMA_TOP)) ? 6'(CHROMA_SPAN) : wsub[5:0];
    luma2_r   <= luma_sum[15:8];

    wprod_r <= wprod;
    luma3_r <= luma2_r;
    for (int c = 0; c < 3; c++) begin
      diff3_r[c] <= $signed({1'b0, pix_r[2].rgb[c]}) - $signed({1'b0, luma2_r});
    end

    q4_r    <= wquo[DIV40_SHIFT +: 9];
    neg4_r  <= wprod_r[16];
    diff4_r <= diff3_r;
    luma4_r <= luma3_r;

    eff5_r  <= neg4_r ? (9'(NEUTRAL_PCT) - q4_r) : (9'(NEUTRAL_PCT) + q4_r);
    diff5_r <= diff4_r;
    luma5_r <= luma4_r;

    out_word_r <= out_word_nxt;
  end

  // one push unit per channel
  for (genvar c = 0; c < 3; c++) begin : g_chan
    vrp_chan_push u_push (
      .clk    (clk),
      .diff_i (diff5_r[c]),
      .eff_i  (eff5_r),
      .luma_i (luma5_r),
      .chan_o (chan8[c])
    );
  end

  // pick raw or pushed channels and pack
  always_comb begin
    if (pix_r[8].bypass) begin
      out_word_nxt = pack_swapped(pix_r[8].rgb[2], pix_r[8].rgb[1], pix_r[8].rgb[0]);
    end else begin
      out_word_nxt = pack_swapped(chan8[2], chan8[1], chan8[0]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_panel_word = out_word_r;

  // checks; the weight of a bypassed pixel is not limited, so its quotient is not
  `VRP_ASSERT(a_latency, out_valid_r |-> $past(valid_r[1], 8))
  `VRP_ASSERT(a_quot_range, (valid_r[4] && !pix_r[4].bypass) |-> (q4_r <= 9'd411))
  `VRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r)

endmodule

[design/vrp_chan_push.sv]
// ---------------------------------------------------------------------------
// vrp_chan_push
// one color channel: scale its distance from luma by the effective percent,
// divide by 100 toward zero, add luma back and clamp to a byte
// ---------------------------------------------------------------------------
module vrp_chan_push
  import vrp_pkg::*;
(
  input  logic  clk,
  input  diff_t diff_i,   // channel minus luma
  input  pct_t  eff_i,    // effective percent
  input  chan_t luma_i,
  output chan_t chan_o
);

  logic signed [18:0] prod_full;
  logic signed [17:0] prod_r;
  chan_t              luma6_r;
  logic [16:0]        mag;
  logic [34:0]        quo_full;
  logic [10:0]        quo_r;
  logic               neg_r;
  chan_t              luma7_r;
  logic signed [11:0] quo_s;
  logic signed [11:0] sum;
  chan_t              chan_nxt;
  chan_t              chan_r;

  // scale the distance
  assign prod_full = diff_i * $signed({1'b0, eff_i});

  // divide magnitude by 100 with a reciprocal
  assign mag      = prod_r[17] ? 17'(-prod_r) : 17'(prod_r);
  assign quo_full = {18'd0, mag} * {17'd0, DIV100_MUL};

  // restore sign, add luma, clamp
  always_comb begin
    quo_s = $signed({1'b0, quo_r});
    if (neg_r) begin
      quo_s = -quo_s;
    end
    sum = $signed({4'd0, luma7_r}) + quo_s;
    if (sum < 0) begin
      chan_nxt = 8'd0;
    end else if (sum > 12'sd255) begin
      chan_nxt = 8'd255;
    end else begin
      chan_nxt = sum[7:0];
    end
  end

  // three payload stages, no reset needed
  always_ff @(posedge clk) begin
    prod_r  <= prod_full[17:0];
    luma6_r <= luma_i;
    quo_r   <= quo_full[DIV100_SHIFT +: 11];
    neg_r   <= prod_r[17];
    luma7_r <= luma6_r;
    chan_r  <= chan_nxt;
  end

  assign chan_o = chan_r;

endmodule

[verif/tb_vibrance_rgb565_pixel_packer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vibrance_rgb565_pixel_packer
// drives rgb888 pixels into the vibrance packer through a queue-fed driver,
// predicts each byte-swapped rgb565 word at the accepting edge and checks
// every output beat in order; saturation is changed between phases only
// while the pipeline is empty
// ---------------------------------------------------------------------------
module tb_vibrance_rgb565_pixel_packer;
  import vrp_pkg::*;

  // signed copies of the gate constants, kept signed for truncating division
  localparam int GRAY_CHROMA  = 24;
  localparam int WEIGHT_SPAN  = 40;
  localparam int UNITY_PCT    = 100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 1380;
  localparam int TAIL_CYCLES  = 20;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [1:0] {STEP_PIXEL, STEP_SAT_WRITE, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t kind;
    chan_t      r, g, b;
    pct_t       sat;
    int         idle_pct;
  } feed_step_t;

  typedef struct {
    logic [15:0] word;
    chan_t       r, g, b;
    pct_t        sat;
  } due_word_t;

  typedef struct packed {
    chan_t r, g, b;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_red_in = '0;
  logic [7:0]  in_green_in = '0;
  logic [7:0]  in_blue_in = '0;
  logic        out_valid;
  logic [15:0] out_panel_word;

  feed_step_t  pixel_feed [$];
  due_word_t   panel_words_due [$];
  pct_t        sat_copy = SAT_RESET;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  vibrance_rgb565_pixel_packer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_panel_word (out_panel_word)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected panel word for one pixel at a given saturation
  function automatic logic [15:0] vibrance_word(chan_t r, chan_t g, chan_t b, pct_t sat);
    int   ch [3];
    int   adj [3];
    int   hi, lo, chroma, weight, boost, luma, v;
    chan_t q [3];
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    hi = ch[0];
    lo = ch[0];
    for (int i = 1; i < 3; i++) begin
      if (ch[i] > hi) hi = ch[i];
      if (ch[i] < lo) lo = ch[i];
    end
    chroma = hi - lo;
    if (chroma <= GRAY_CHROMA || int'(sat) == UNITY_PCT) begin
      adj = ch;
    end else begin
      weight = chroma - GRAY_CHROMA;
      if (weight > WEIGHT_SPAN) weight = WEIGHT_SPAN;
      boost = UNITY_PCT + ((int'(sat) - UNITY_PCT) * weight) / WEIGHT_SPAN;
      luma = (77 * ch[0] + 150 * ch[1] + 29 * ch[2]) >> 8;
      for (int i = 0; i < 3; i++) begin
        v = luma + ((ch[i] - luma) * boost) / UNITY_PCT;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        adj[i] = v;
      end
    end
    for (int i = 0; i < 3; i++) q[i] = adj[i][7:0];
    // {r5,g6,b5} with low byte first
    return {q[1][4:2], q[2][7:3], q[0][7:3], q[1][7:5]};
  endfunction

  // pixel mix: plain random, chroma near the gate and the weight span, rail values
  function automatic rgb_t random_rgb();
    int   mode, spread, lo, rot;
    int   c [3];
    rgb_t px;
    mode = $urandom_range(9);
    if (mode < 4) begin
      for (int i = 0; i < 3; i++) c[i] = $urandom_range(255);
    end else if (mode < 8) begin
      spread = $urandom_range(80);
      lo = $urandom_range(255 - spread);
      rot = $urandom_range(5);
      c[rot % 3] = lo;
      c[(rot + 1 + rot / 3) % 3] = lo + spread;
      c[(rot + 2 - rot / 3) % 3] = lo + $urandom_range(spread);
    end else begin
      for (int i = 0; i < 3; i++)
        c[i] = $urandom_range(1) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
    end
    px.r = c[0][7:0];
    px.g = c[1][7:0];
    px.b = c[2][7:0];
    return px;
  endfunction

  task automatic add_pixel(chan_t r, chan_t g, chan_t b, int idle_pct);
    feed_step_t s;
    s.kind = STEP_PIXEL;
    s.r = r;
    s.g = g;
    s.b = b;
    s.sat = '0;
    s.idle_pct = idle_pct;
    pixel_feed.push_back(s);
  endtask

  task automatic add_step(step_kind_t kind, pct_t sat);
    feed_step_t s;
    s.kind = kind;
    s.r = '0;
    s.g = '0;
    s.b = '0;
    s.sat = sat;
    s.idle_pct = 0;
    pixel_feed.push_back(s);
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // driver: one beat held on start until taken, writes only when idle
  always @(posedge clk) begin : driver
    feed_step_t head;
    logic       taken, nxt_start, nxt_we;
    taken = start && !busy;
    nxt_start = start && !taken;
    nxt_we = 1'b0;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else if (!nxt_start && pixel_feed.size() != 0) begin
      head = pixel_feed[0];
      case (head.kind)
        STEP_PIXEL: begin
          if ($urandom_range(99) >= head.idle_pct) begin
            void'(pixel_feed.pop_front());
            nxt_start = 1'b1;
            in_red_in <= head.r;
            in_green_in <= head.g;
            in_blue_in <= head.b;
          end
        end
        STEP_SAT_WRITE: begin
          if (!start && panel_words_due.size() == 0) begin
            void'(pixel_feed.pop_front());
            nxt_we = 1'b1;
            cfg_wdata <= head.sat;
          end
        end
        STEP_DRAIN: begin
          if (!start && panel_words_due.size() == 0) void'(pixel_feed.pop_front());
        end
        default: void'(pixel_feed.pop_front());
      endcase
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor: register copy, prediction at the accepting edge, in-order check
  always @(posedge clk) begin : monitor
    due_word_t due;
    cycle_count++;
    if (!rst_n) begin
      sat_copy = SAT_RESET;
    end else begin
      if (out_valid !== 1'b0) begin
        if (panel_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: panel_word %h", out_panel_word));
        end else begin
          due = panel_words_due.pop_front();
          if (out_panel_word !== due.word)
            report_mismatch($sformatf(
              "panel_word mismatch rgb=%0d,%0d,%0d sat=%0d: expected %h got %h",
              due.r, due.g, due.b, due.sat, due.word, out_panel_word));
        end
      end
      if (cfg_we === 1'b1) sat_copy = cfg_wdata;
      if (start && !busy) begin
        due.r = in_red_in;
        due.g = in_green_in;
        due.b = in_blue_in;
        due.sat = sat_copy;
        due.word = vibrance_word(in_red_in, in_green_in, in_blue_in, sat_copy);
        panel_words_due.push_back(due);
      end
    end
    // hang guard
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL vibrance_rgb565_pixel_packer");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    rgb_t  px;
    pct_t  sat_plan [10];
    int    per_phase, idle, k;
    rgb_t  directed [12];
    directed = '{
      '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255}, '{8'd124, 8'd100, 8'd100},
      '{8'd125, 8'd100, 8'd100}, '{8'd164, 8'd100, 8'd100},
      '{8'd165, 8'd100, 8'd100}, '{8'd255, 8'd255, 8'd0},
      '{8'd8,   8'd4,   8'd250}, '{8'd200, 8'd180, 8'd10}};
    // neutral setting from reset, then a boost of 400 with clamping
    foreach (directed[i]) add_pixel(directed[i].r, directed[i].g, directed[i].b, 0);
    add_step(STEP_SAT_WRITE, 9'd400);
    foreach (directed[i]) add_pixel(directed[i].r, directed[i].g, directed[i].b, 0);

    // random phases, including grayscale, above-range values and neutral again
    sat_plan = '{9'd0, 9'd511, 9'd401, 9'd250, 9'd100, 9'd1, 9'd150, 9'd75, 9'd400, 9'd0};
    sat_plan[9] = pct_t'($urandom_range(511));
    per_phase = RANDOM_BEATS / 10;
    k = 0;
    foreach (sat_plan[p]) begin
      add_step(STEP_SAT_WRITE, sat_plan[p]);
      for (int i = 0; i < per_phase; i++) begin
        idle = (k < RANDOM_BEATS / 3) ? 18 : (k < 2 * RANDOM_BEATS / 3) ? 58 : 0;
        px = random_rgb();
        add_pixel(px.r, px.g, px.b, idle);
        if ($urandom_range(99) == 0) add_step(STEP_DRAIN, '0);
        k++;
      end
    end
    add_step(STEP_DRAIN, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_feed.size() != 0 || start) @(posedge clk);
    while (panel_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (panel_words_due.size() != 0)
      report_mismatch($sformatf("%0d panel words never arrived", panel_words_due.size()));

    if (mismatch_count == 0) begin
      $display("PASS vibrance_rgb565_pixel_packer");
    end else begin
      $display("FAIL vibrance_rgb565_pixel_packer");
    end
    $finish;
  end

endmodule
